@@ hw/rtl/pcanon_pkg.sv @@
// package for the path canonicaliser
// shared byte codes and the command and status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package pcanon_pkg;

	localparam logic [7:0] SEP_BYTE = 8'h2F;
	localparam logic [7:0] DOT_BYTE = 8'h2E;

	typedef struct packed {
		logic step;
		logic close;
		logic emit;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic emit_last;
	} dp_status_t;

endpackage

@@ hw/rtl/pcanon_ctrl.sv @@
// controller state machine of the path canonicaliser
// sequences byte intake, final segment close and emission
// depends on pcanon_pkg
`timescale 1ns / 1ps

module pcanon_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  path_end,
	output logic                  in_ready,
	output pcanon_pkg::dp_cmd_t   cmd,
	input  pcanon_pkg::dp_status_t status
);

	typedef enum logic [1:0] {
		S_ACCEPT,
		S_CLOSE,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   in_take;

	assign in_take  = ready_q && in_valid;
	assign in_ready = ready_q;

	always_comb begin
		cmd       = '0;
		cmd.step  = in_take;
		cmd.close = (state_q == S_CLOSE);
		cmd.emit  = (state_q == S_EMIT) && status.out_free;
		cmd.clear = (state_q == S_EMIT) && status.out_free && status.emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCEPT;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_ACCEPT: begin
					if (in_take && path_end) begin
						state_q <= S_CLOSE;
						ready_q <= 1'b0;
					end
				end
				S_CLOSE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (status.out_free && status.emit_last) begin
						state_q <= S_ACCEPT;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_ACCEPT;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/pcanon_dp.sv @@
// datapath of the path canonicaliser
// text buffer, segment start stack, counters and the output register
// depends on pcanon_pkg
`timescale 1ns / 1ps

module pcanon_dp #(
	parameter int MAX_OUT   = 64,
	parameter int MAX_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcanon_pkg::dp_cmd_t    cmd,
	output pcanon_pkg::dp_status_t status,
	input  logic [7:0]             path_byte,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [7:0]             out_byte,
	output logic                   out_last,
	output logic                   overflowed
);

	localparam int LW = $clog2(MAX_OUT + 1);
	localparam int AW = $clog2(MAX_OUT);
	localparam int PW = LW + 1;
	localparam int TW = $clog2(MAX_DEPTH + 1);
	localparam int DW = $clog2(MAX_DEPTH);

	logic [7:0]    text_mem [MAX_OUT];
	logic [LW-1:0] start_mem [MAX_DEPTH];

	logic [LW-1:0] kept_q;
	logic [LW-1:0] seg_q;
	logic          dots_q;
	logic          ovf_q;
	logic [TW-1:0] top_q;
	logic [LW-1:0] top_start_q;
	logic [LW-1:0] emit_idx_q;

	logic          out_valid_q;
	logic [7:0]    text_q;
	logic          lone_q;
	logic          last_q;
	logic          ovf_out_q;

	logic          is_sep;
	logic          do_take;
	logic          do_close;
	logic          seg_open;
	logic          is_dot1;
	logic          is_dot2;
	logic          stack_full;
	logic          pop;
	logic          push;
	logic          drop;
	logic [PW-1:0] end_sum;
	logic          end_over;
	logic          pos_in;
	logic [TW-1:0] next_top;
	logic [DW-1:0] start_idx;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          emit_last;

	assign is_sep     = (path_byte == pcanon_pkg::SEP_BYTE);
	assign do_take    = cmd.step && !is_sep;
	assign do_close   = cmd.close || (cmd.step && is_sep);
	assign seg_open   = (seg_q != '0);
	assign is_dot1    = dots_q && (seg_q == LW'(1));
	assign is_dot2    = dots_q && (seg_q == LW'(2));
	assign stack_full = (top_q == TW'(MAX_DEPTH));
	assign pop        = do_close && seg_open && is_dot2 && (top_q != '0);
	assign push       = do_close && seg_open && !is_dot1 && !is_dot2 && !stack_full;
	assign drop       = do_close && seg_open && !is_dot1 && !is_dot2 && stack_full;

	// position of the next byte equals the end of the segment once closed
	assign end_sum  = {1'b0, kept_q} + {1'b0, seg_q} + PW'(1);
	assign end_over = (end_sum > PW'(MAX_OUT));
	assign pos_in   = (end_sum < PW'(MAX_OUT));

	always_comb begin
		next_top = top_q;
		if (pop) begin
			next_top = top_q - TW'(1);
		end else if (push) begin
			next_top = top_q + TW'(1);
		end
		if (next_top == '0) begin
			start_idx = '0;
		end else begin
			start_idx = DW'(next_top - TW'(1));
		end
	end

	// separator of a kept segment is written when it is pushed
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = end_sum[AW-1:0];
		wr_data = path_byte;
		if (do_take && pos_in) begin
			wr_en = 1'b1;
		end else if (push && (kept_q < LW'(MAX_OUT))) begin
			wr_en   = 1'b1;
			wr_addr = kept_q[AW-1:0];
			wr_data = pcanon_pkg::SEP_BYTE;
		end
	end

	assign emit_last = (kept_q == '0) || ((emit_idx_q + LW'(1)) == kept_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_mem[wr_addr] <= wr_data;
		end
		if (cmd.emit) begin
			text_q <= text_mem[emit_idx_q[AW-1:0]];
		end
	end

	// top_start_q always mirrors the start of the topmost kept segment
	always_ff @(posedge clk) begin
		if (push) begin
			start_mem[top_q[DW-1:0]] <= kept_q;
			top_start_q              <= kept_q;
		end else begin
			top_start_q <= start_mem[start_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q     <= '0;
			seg_q      <= '0;
			dots_q     <= 1'b1;
			ovf_q      <= 1'b0;
			top_q      <= '0;
			emit_idx_q <= '0;
		end else if (cmd.clear) begin
			kept_q     <= '0;
			seg_q      <= '0;
			dots_q     <= 1'b1;
			ovf_q      <= 1'b0;
			top_q      <= '0;
			emit_idx_q <= '0;
		end else begin
			if (do_take) begin
				if (path_byte != pcanon_pkg::DOT_BYTE) begin
					dots_q <= 1'b0;
				end
				if (seg_q < LW'(MAX_OUT)) begin
					seg_q <= seg_q + LW'(1);
				end
			end
			if (do_close) begin
				seg_q  <= '0;
				dots_q <= 1'b1;
				top_q  <= next_top;
				if (pop) begin
					kept_q <= top_start_q;
				end else if (push) begin
					kept_q <= end_over ? LW'(MAX_OUT) : end_sum[LW-1:0];
				end
				if ((push && end_over) || drop) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				emit_idx_q <= emit_idx_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			lone_q    <= (kept_q == '0);
			last_q    <= emit_last;
			ovf_out_q <= ovf_q;
		end
	end

	assign status.out_free  = !out_valid_q || out_ready;
	assign status.emit_last = emit_last;

	assign out_valid  = out_valid_q;
	assign out_byte   = lone_q ? pcanon_pkg::SEP_BYTE : text_q;
	assign out_last   = last_q;
	assign overflowed = ovf_out_q;

endmodule

@@ hw/rtl/path_canonicalizer.sv @@
// top level of the path canonicaliser
// joins the controller and the datapath
// depends on pcanon_pkg, pcanon_ctrl, pcanon_dp
`timescale 1ns / 1ps

// input channel: in_valid/in_ready with path_byte and path_end, one path
// character per transaction; path_end marks the final character.
// intake runs at one character per cycle while in_ready is high; each
// character updates the segment counters and writes at most one byte of
// the text buffer. after the final character the close state closes the
// open segment, then the canonical path leaves on the output channel
// (out_valid/out_ready with out_byte, out_last, overflowed), one byte per
// cycle while the receiver takes them, from the text buffer read port,
// through an output register. a path with no kept segment gives a lone
// separator. overflowed holds the sticky flag on every byte of a path.
// in_ready is low from the final character until the last result is loaded
// into the output register; a stalled receiver holds the emission there.
// reset (arst_n, asynchronous) empties all counters and the output register;
// the buffers need no clearing, in_ready is high straight after reset.
// MAX_OUT sets the text buffer size, MAX_DEPTH the segment stack depth.

module path_canonicalizer #(
	parameter int MAX_OUT   = 64,
	parameter int MAX_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] path_byte,
	input  logic       path_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       overflowed
);

	pcanon_pkg::dp_cmd_t    cmd;
	pcanon_pkg::dp_status_t status;

	pcanon_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.path_end (path_end),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	pcanon_dp #(
		.MAX_OUT   (MAX_OUT),
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.path_byte  (path_byte),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.overflowed (overflowed)
	);

endmodule

@@ hw/rtl/pcanon_checker.sv @@
// port-level checker for the path canonicaliser, bound to the top level
// depends on path_canonicalizer
`timescale 1ns / 1ps

module pcanon_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       path_end,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       overflowed
);

	// stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
		&& $stable(overflowed))
		else $error("output payload changed under stall");

	// intake stops after the final character of a path
	a_end_stops_intake: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && path_end |=> !in_ready)
		else $error("in_ready still high after final character");

	// no intake while a path is still being emitted
	a_no_intake_mid_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("in_ready high during emission");

	// overflow flag is the same across one canonical path
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last ##1 out_valid |-> $stable(overflowed))
		else $error("overflow flag changed within a path");

endmodule

bind path_canonicalizer pcanon_checker u_pcanon_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.path_end   (path_end),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.out_last   (out_last),
	.overflowed (overflowed)
);

@@ tb/tb_path_canonicalizer.sv @@
// self-checking testbench for path_canonicalizer: directed and random paths with
// random idling on both channels, checked against a behavioural predictor
// depends on pcanon_pkg and path_canonicalizer
`timescale 1ns / 1ps

module tb_path_canonicalizer;

	localparam int MAX_OUT    = 64;
	localparam int MAX_DEPTH  = 32;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       ovf;
	} canon_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] path_byte = 8'h00;
	logic       path_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       overflowed;

	// predictor state
	logic [7:0] canon_text [MAX_OUT];
	int         seg_start [MAX_DEPTH];
	int         kept_len = 0;
	int         depth = 0;
	int         seg_len = 0;
	bit         only_dots = 1'b1;
	bit         path_ovf = 1'b0;

	canon_char_t expected_chars [$];
	logic [7:0]  path_chars [$];

	bit steady = 1'b0;
	int errors = 0;
	int paths_sent = 0;
	int chars_sent = 0;
	int bytes_checked = 0;
	int ovf_paths = 0;
	int quiet_cycles = 0;

	path_canonicalizer #(
		.MAX_OUT   (MAX_OUT),
		.MAX_DEPTH (MAX_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.path_byte  (path_byte),
		.path_end   (path_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.overflowed (overflowed)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void canon_close();
		int stop;
		if (seg_len != 0) begin
			if (only_dots && seg_len == 2) begin
				if (depth > 0) begin
					depth--;
					kept_len = seg_start[depth];
				end
			end else if (!(only_dots && seg_len == 1)) begin
				if (depth >= MAX_DEPTH) begin
					path_ovf = 1'b1;
				end else begin
					stop = kept_len + 1 + seg_len;
					seg_start[depth] = kept_len;
					depth++;
					if (stop > MAX_OUT) begin
						stop = MAX_OUT;
						path_ovf = 1'b1;
					end
					kept_len = stop;
				end
			end
		end
		seg_len = 0;
		only_dots = 1'b1;
	endfunction

	function automatic void canon_take(input logic [7:0] b, input logic fin);
		int pos;
		int n;
		canon_char_t c;
		if (b == pcanon_pkg::SEP_BYTE) begin
			canon_close();
		end else begin
			pos = kept_len + 1 + seg_len;
			if (seg_len == 0 && kept_len < MAX_OUT)
				canon_text[kept_len] = pcanon_pkg::SEP_BYTE;
			if (pos < MAX_OUT)
				canon_text[pos] = b;
			if (b != pcanon_pkg::DOT_BYTE)
				only_dots = 1'b0;
			if (seg_len < MAX_OUT)
				seg_len++;
		end
		if (fin) begin
			canon_close();
			n = (kept_len > MAX_OUT) ? MAX_OUT : kept_len;
			c.ovf = path_ovf;
			if (n == 0) begin
				c.ch = pcanon_pkg::SEP_BYTE;
				c.last = 1'b1;
				expected_chars.insert(expected_chars.size(), c);
			end else begin
				for (int k = 0; k < n; k++) begin
					c.ch = canon_text[k];
					c.last = (k == n - 1);
					expected_chars.insert(expected_chars.size(), c);
				end
			end
			if (path_ovf)
				ovf_paths++;
			kept_len = 0;
			depth = 0;
			seg_len = 0;
			only_dots = 1'b1;
			path_ovf = 1'b0;
		end
	endfunction

	// result check, then prediction for the accepted character, then watchdog
	always @(posedge clk) begin
		canon_char_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				bytes_checked++;
				if (expected_chars.size() == 0) begin
					$error("unexpected output transaction: out_byte %h", out_byte);
					errors++;
				end else begin
					e = expected_chars.pop_front();
					if (out_byte !== e.ch) begin
						$error("out_byte expected %h got %h", e.ch, out_byte);
						errors++;
					end
					if (out_last !== e.last) begin
						$error("out_last expected %b got %b", e.last, out_last);
						errors++;
					end
					if (overflowed !== e.ovf) begin
						$error("overflowed expected %b got %b", e.ovf, overflowed);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				canon_take(path_byte, path_end);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("[path_canonicalizer] ERROR");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 32);
	end

	task automatic send_char(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		path_byte <= b;
		path_end <= fin;
		do @(posedge clk); while (!in_ready);
		chars_sent++;
	endtask

	task automatic send_path();
		for (int i = 0; i < path_chars.size(); i++)
			send_char(path_chars[i], i == path_chars.size() - 1);
		path_chars.delete();
		paths_sent++;
	endtask

	function automatic void append_char(input logic [7:0] b);
		path_chars.insert(path_chars.size(), b);
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
	endtask

	task automatic add_rep(input logic [7:0] b, input int n);
		repeat (n) append_char(b);
	endtask

	task automatic run_text(input string s);
		add_text(s);
		send_path();
	endtask

	task automatic test_plain_paths();
		run_text("/");
		run_text("///");
		run_text("/home/user/docs");
		run_text("a//b/");
		run_text("x");
	endtask

	task automatic test_dot_segments();
		run_text(".");
		run_text("..");
		run_text("/../../");
		run_text("/a/./b/../c");
		run_text("/.../..../x/..");
		run_text("/a/b/../../..");
		run_text(".h/..a/a..");
	endtask

	task automatic test_byte_extremes();
		add_rep(8'h00, 1);
		add_rep(8'hFF, 1);
		add_rep(pcanon_pkg::SEP_BYTE, 1);
		add_rep(8'h80, 1);
		add_rep(8'h7F, 1);
		add_rep(pcanon_pkg::SEP_BYTE, 1);
		add_rep(8'h01, 1);
		add_rep(8'hFE, 1);
		send_path();
	endtask

	task automatic test_text_overflow();
		// one name longer than the buffer, also saturating the segment length;
		// overflow stays flagged after ".." brings the text back in range
		add_text("/");
		add_rep("x", 70);
		add_text("/../c");
		send_path();
		// exactly fills the buffer
		add_text("/");
		add_rep("d", 63);
		send_path();
	endtask

	task automatic test_stack_overflow();
		// one name past a full stack is dropped, then ".." pops from the full stack
		repeat (MAX_DEPTH + 1) add_text("/b");
		add_text("/../e");
		send_path();
	endtask

	task automatic add_name(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			do b = 8'($urandom_range(255)); while (b == pcanon_pkg::SEP_BYTE);
			append_char(b);
		end
	endtask

	task automatic test_random_paths(input int n_chars);
		int target;
		int segs;
		int kind;
		target = chars_sent + n_chars;
		while (chars_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 12) begin
				// noise biased towards separators and dots
				repeat ($urandom_range(1, 20)) begin
					case ($urandom_range(3))
						0: append_char(pcanon_pkg::SEP_BYTE);
						1: append_char(pcanon_pkg::DOT_BYTE);
						default: append_char(8'($urandom_range(255)));
					endcase
				end
			end else if (kind < 17) begin
				// deep or long paths that run into the limits
				segs = $urandom_range(20, MAX_DEPTH + 4);
				repeat (segs) begin
					append_char(pcanon_pkg::SEP_BYTE);
					if ($urandom_range(5) == 0)
						add_text("..");
					else
						add_name($urandom_range(1, 3));
				end
			end else begin
				segs = $urandom_range(1, 8);
				if ($urandom_range(1))
					append_char(pcanon_pkg::SEP_BYTE);
				repeat (segs) begin
					case ($urandom_range(7))
						0: ;
						1: add_text(".");
						2: add_text("..");
						3: add_text("...");
						default: add_name($urandom_range(1, 8));
					endcase
					append_char(pcanon_pkg::SEP_BYTE);
				end
				if ($urandom_range(1) && path_chars.size() > 1)
					path_chars.delete(path_chars.size() - 1);
			end
			send_path();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_paths();
		test_dot_segments();
		test_byte_extremes();
		test_text_overflow();
		test_stack_overflow();
		test_random_paths(40);
		steady = 1'b1;
		test_random_paths(50);
		steady = 1'b0;
		test_random_paths(40);
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d paths, %0d input characters, %0d output bytes checked",
			paths_sent, chars_sent, bytes_checked);
		$display("%0d paths overflowed, %0d mismatches", ovf_paths, errors);
		if (errors == 0)
			$display("[path_canonicalizer] OK");
		else
			$display("[path_canonicalizer] ERROR");
		$finish;
	end

endmodule
